/* hw/rtl/rtdlin_pkg.sv */
// Package for the RTD temperature linearizer: field widths, word types,
// register indexes and the fixed-point constants of the quadratic solution.
// No dependencies; every module of the block imports it.
package rtdlin_pkg;

    localparam int unsigned CODE_W     = 15;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned FLAG_W     = 8;
    localparam int unsigned REF_W      = 19;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned OFS_W      = 14;
    localparam int unsigned TEMP_W     = 19;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_OHMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_OFFSET    = 2'd2;

    localparam logic [REF_W-1:0]         RST_REFERENCE = 19'd27520;
    localparam logic signed [GAIN_W-1:0] RST_GAIN      = 16'sd16384;
    localparam logic signed [OFS_W-1:0]  RST_OFFSET    = 14'sd0;

    localparam int unsigned NUM_W    = CODE_W + REF_W;
    localparam int unsigned DVD_W    = NUM_W + 3;
    localparam int unsigned U_W      = 27;
    localparam int unsigned COEF_W   = 36;
    localparam int unsigned TERM_SH  = 12;
    localparam int unsigned TERM_W   = COEF_W + U_W - TERM_SH;
    localparam int unsigned W_W      = 52;
    localparam int unsigned S_W      = W_W / 2;
    localparam int unsigned SQ_CNT_W = $clog2(S_W);
    localparam int unsigned X_W      = 37;
    localparam int unsigned XM_W     = X_W - 1;
    localparam int unsigned R2_W     = 15;
    localparam int unsigned T_W      = 22;
    localparam int unsigned P_W      = 38;
    localparam int unsigned Q_W      = P_W + 1;
    localparam int unsigned FRAC_W   = 14;
    localparam int unsigned Y_W      = Q_W - FRAC_W;
    localparam int unsigned CNT_W    = $clog2(DVD_W);

    localparam logic [TERM_W-1:0]       A_SQ_E20 = 51'd1527480889000000;
    localparam logic [COEF_W-1:0]       FOUR_B_Q = 36'd56396484375;
    localparam logic signed [X_W-1:0]   X_BIAS   = 37'sd20010507550;
    localparam logic [R2_W-1:0]         TWO_B2   = 15'd23100;
    localparam logic [FRAC_W-1:0]       HALF_LSB = 14'd8192;
    localparam logic signed [Y_W-1:0]   TEMP_MIN = -25'sd65536;
    localparam logic signed [Y_W-1:0]   TEMP_MAX = 25'sd262143;

    typedef struct packed {
        logic              data_ready;
        logic [WORD_W-1:0] rtd_word;
        logic [FLAG_W-1:0] fault_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     fresh;
        logic                     clear_fault;
        logic [FLAG_W-1:0]        fault_flags;
    } t_out_word;

endpackage

/* hw/rtl/rtdlin_stream_if.sv */
// Valid/ready channel used for the readout words and the result words.
// The payload type is given at instantiation, normally a word type of rtdlin_pkg.
interface rtdlin_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rtdlin_isqrt.sv */
// Bit-pair serial integer square root: two radicand bits and one root bit per cycle.
// Depends on rtdlin_pkg for the radicand and root widths.
module rtdlin_isqrt import rtdlin_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W_W-1:0] i_radicand,
    output logic           o_done,
    output logic [S_W-1:0] o_root
);

    logic [W_W-1:0]      r_x, n_x;
    logic [S_W+1:0]      r_rem, n_rem;
    logic [S_W-1:0]      r_root, n_root;
    logic [SQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic [S_W+3:0]      cur;
    logic [S_W+3:0]      trial;
    logic [S_W+3:0]      diff;
    logic                fits;

    assign cur   = {r_rem, r_x[W_W-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign diff  = cur - trial;
    assign fits  = (cur >= trial);

    always_comb begin
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_x    = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = SQ_CNT_W'(S_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_x    = {r_x[W_W-3:0], 2'b00};
            n_rem  = fits ? diff[S_W+1:0] : cur[S_W+1:0];
            n_root = {r_root[S_W-2:0], fits};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root;

endmodule

/* hw/rtl/rtd_temperature_linearizer.sv */
// Top level of the RTD temperature linearizer: converter readout in, calibrated
// temperature out. Depends on rtdlin_pkg, rtdlin_stream_if and rtdlin_isqrt.
//
// Use: each readout word on i_in (data_ready, rtd_word, fault_byte) yields exactly
// one result word on o_out (temperature, fresh, clear_fault, fault_flags). Both
// channels are valid/ready; a word moves when valid and ready are high together.
// Registers (reference resistance, span gain, span offset) are written through
// i_cfg_we/i_cfg_idx/i_cfg_data, by the user only while idle; the block does not enforce it.
// A readout that is not ready, or that carries the fault bit, goes from acceptance
// straight to the output load. A good readout is worked one bit per cycle through,
// in order: code by reference multiply, difference, ratio division by the nominal
// resistance, discriminant multiply, discriminant, square root with its start,
// quotient set-up, division by twice the B coefficient, sign fix, gain multiply,
// calibration and output load. One readout is in work at a time; i_in.ready is
// high again once its result sits in the output register, and a result waiting
// there does not hold off the next readout. If the receiver stalls, the result is
// held and a finished next result waits until the output register is free.
// Reset restores the register defaults, clears the held temperature and fault
// flags and empties the output register.
module rtd_temperature_linearizer import rtdlin_pkg::*; #(
    parameter int unsigned NOMINAL_OHMS = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rtdlin_stream_if.sink         i_in,
    rtdlin_stream_if.source       o_out
);

    localparam longint unsigned DEN_L = longint'(NOMINAL_OHMS) << 21;
    localparam logic [NUM_W-1:0] DEN  = NUM_W'(DEN_L);
    localparam logic [NUM_W:0]   NUM9 = (NUM_W + 1)'(9 * DEN_L);
    localparam int unsigned      R1_W = $clog2(NOMINAL_OHMS + 1);
    localparam logic [R1_W:0]    NOM_T = (R1_W + 1)'(NOMINAL_OHMS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_DISC = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_DV2P = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;
    localparam logic [3:0] S_TFIX = 4'd9;
    localparam logic [3:0] S_MUL3 = 4'd10;
    localparam logic [3:0] S_CAL  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_sq_go, n_sq_go;
    logic                     r_ovalid, n_ovalid;
    logic [REF_W-1:0]         r_ref, n_ref;
    logic signed [GAIN_W-1:0] r_gain, n_gain;
    logic signed [OFS_W-1:0]  r_ofs, n_ofs;
    logic signed [TEMP_W-1:0] r_held_temp, n_held_temp;
    logic [FLAG_W-1:0]        r_held_flags, n_held_flags;

    logic [CODE_W-1:0]        r_code, n_code;
    logic [NUM_W-1:0]         r_acc1, n_acc1;
    logic                     r_neg, n_neg;
    logic                     r_big, n_big;
    logic [DVD_W-1:0]         r_dvd, n_dvd;
    logic [R1_W-1:0]          r_rem1, n_rem1;
    logic [COEF_W-1:0]        r_hi, n_hi;
    logic [U_W-1:0]           r_lo, n_lo;
    logic [W_W-1:0]           r_w, n_w;
    logic [XM_W-1:0]          r_dvd2, n_dvd2;
    logic [R2_W-1:0]          r_rem2, n_rem2;
    logic                     r_neg2, n_neg2;
    logic [T_W-1:0]           r_t, n_t;
    logic signed [P_W-1:0]    r_acc3, n_acc3;
    logic                     r_fresh, n_fresh;
    logic                     r_clr, n_clr;
    t_out_word                r_out, n_out;

    logic [NUM_W-1:0]         mul1_sum;
    logic [NUM_W-1:0]         diff_up;
    logic [NUM_W-1:0]         diff_dn;
    logic                     is_neg;
    logic                     is_big;
    logic [R1_W:0]            div1_trial;
    logic [R1_W:0]            div1_diff;
    logic                     div1_ge;
    logic [COEF_W:0]          mul2_sum;
    logic [TERM_W-1:0]        term;
    logic [W_W-1:0]           disc_add;
    logic [W_W-1:0]           disc_sub;
    logic [S_W-1:0]           sq_root;
    logic                     sq_done;
    logic signed [X_W-1:0]    x2;
    logic [XM_W-1:0]          mag2;
    logic [R2_W:0]            div2_trial;
    logic [R2_W:0]            div2_diff;
    logic                     div2_ge;
    logic signed [P_W-1:0]    gain_ext;
    logic signed [P_W-1:0]    mul3_add;
    logic signed [Q_W-1:0]    cal_sum;
    logic signed [Y_W-1:0]    cal_y;
    logic signed [TEMP_W-1:0] cal_sat;
    logic                     in_take;

    rtdlin_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_go),
        .i_radicand (r_w),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign mul1_sum = {r_acc1[NUM_W-2:0], 1'b0}
                    + (r_code[CODE_W-1] ? NUM_W'(r_ref) : '0);
    assign diff_up  = r_acc1 - DEN;
    assign diff_dn  = DEN - r_acc1;
    assign is_neg   = (r_acc1 > DEN);
    assign is_big   = ({1'b0, r_acc1} >= NUM9);

    assign div1_trial = {r_rem1, r_dvd[DVD_W-1]};
    assign div1_diff  = div1_trial - NOM_T;
    assign div1_ge    = (div1_trial >= NOM_T);

    assign mul2_sum = {1'b0, r_hi} + (r_dvd[0] ? {1'b0, FOUR_B_Q} : '0);
    assign term     = {r_hi, r_lo[U_W-1:TERM_SH]};
    assign disc_add = {1'b0, A_SQ_E20} + {1'b0, term};
    assign disc_sub = {1'b0, A_SQ_E20} - {1'b0, term};

    assign x2   = X_BIAS - signed'({2'b00, sq_root, 9'b0});
    assign mag2 = x2[X_W-1] ? ~x2[XM_W-1:0] : x2[XM_W-1:0];

    assign div2_trial = {r_rem2, r_dvd2[XM_W-1]};
    assign div2_diff  = div2_trial - {1'b0, TWO_B2};
    assign div2_ge    = (div2_trial >= {1'b0, TWO_B2});

    assign gain_ext = {{(P_W - GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
    assign mul3_add = !r_t[T_W-1] ? '0
                    : (r_cnt == CNT_W'(T_W - 1)) ? -gain_ext : gain_ext;

    assign cal_sum = {r_acc3[P_W-1], r_acc3}
                   + {{(Q_W - OFS_W - FRAC_W){r_ofs[OFS_W-1]}}, r_ofs, HALF_LSB};
    assign cal_y   = cal_sum[Q_W-1:FRAC_W];
    assign cal_sat = (cal_y < TEMP_MIN) ? TEMP_MIN[TEMP_W-1:0]
                   : (cal_y > TEMP_MAX) ? TEMP_MAX[TEMP_W-1:0]
                   : cal_y[TEMP_W-1:0];

    assign in_take = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        n_ref  = r_ref;
        n_gain = r_gain;
        n_ofs  = r_ofs;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REFERENCE_OHMS: n_ref  = i_cfg_data[REF_W-1:0];
                CFG_SPAN_GAIN:      n_gain = i_cfg_data[GAIN_W-1:0];
                CFG_SPAN_OFFSET:    n_ofs  = i_cfg_data[OFS_W-1:0];
                default:            n_ref  = r_ref;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sq_go      = 1'b0;
        n_ovalid     = r_ovalid && !o_out.ready;
        n_held_temp  = r_held_temp;
        n_held_flags = r_held_flags;
        n_code       = r_code;
        n_acc1       = r_acc1;
        n_neg        = r_neg;
        n_big        = r_big;
        n_dvd        = r_dvd;
        n_rem1       = r_rem1;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_w          = r_w;
        n_dvd2       = r_dvd2;
        n_rem2       = r_rem2;
        n_neg2       = r_neg2;
        n_t          = r_t;
        n_acc3       = r_acc3;
        n_fresh      = r_fresh;
        n_clr        = r_clr;
        n_out        = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_fresh = 1'b0;
                    n_clr   = 1'b0;
                    n_state = S_FIN;
                    if (i_in.payload.data_ready) begin
                        n_held_flags = i_in.payload.fault_byte;
                        if (i_in.payload.rtd_word[0]) begin
                            n_clr = 1'b1;
                        end else begin
                            n_fresh = 1'b1;
                            n_code  = i_in.payload.rtd_word[WORD_W-1:1];
                            n_acc1  = '0;
                            n_cnt   = CNT_W'(CODE_W - 1);
                            n_state = S_MUL1;
                        end
                    end
                end
            end
            S_MUL1: begin
                n_acc1 = mul1_sum;
                n_code = {r_code[CODE_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_neg   = is_neg;
                n_big   = is_big;
                n_dvd   = {(is_neg ? diff_up : diff_dn), 3'b000};
                n_rem1  = '0;
                n_cnt   = CNT_W'(DVD_W - 1);
                n_state = S_DIV1;
            end
            S_DIV1: begin
                n_rem1 = div1_ge ? div1_diff[R1_W-1:0] : div1_trial[R1_W-1:0];
                n_dvd  = {r_dvd[DVD_W-2:0], div1_ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_hi    = '0;
                    n_cnt   = CNT_W'(U_W - 1);
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_hi  = mul2_sum[COEF_W:1];
                n_lo  = {mul2_sum[0], r_lo[U_W-1:1]};
                n_dvd = {1'b0, r_dvd[DVD_W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DISC;
                end
            end
            S_DISC: begin
                if (r_big) begin
                    n_w = '0;
                end else if (!r_neg) begin
                    n_w = disc_add;
                end else if (disc_sub[W_W-1]) begin
                    n_w = '0;
                end else begin
                    n_w = disc_sub;
                end
                n_sq_go = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_state = S_DV2P;
                end
            end
            S_DV2P: begin
                n_neg2  = x2[X_W-1];
                n_dvd2  = mag2;
                n_rem2  = '0;
                n_cnt   = CNT_W'(XM_W - 1);
                n_state = S_DIV2;
            end
            S_DIV2: begin
                n_rem2 = div2_ge ? div2_diff[R2_W-1:0] : div2_trial[R2_W-1:0];
                n_dvd2 = {r_dvd2[XM_W-2:0], div2_ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_TFIX;
                end
            end
            S_TFIX: begin
                n_t     = r_dvd2[T_W-1:0] ^ {T_W{r_neg2}};
                n_acc3  = '0;
                n_cnt   = CNT_W'(T_W - 1);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_acc3 = {r_acc3[P_W-2:0], 1'b0} + mul3_add;
                n_t    = {r_t[T_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_CAL;
                end
            end
            S_CAL: begin
                n_held_temp = cal_sat;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out.temperature = r_held_temp;
                    n_out.fresh       = r_fresh;
                    n_out.clear_fault = r_clr;
                    n_out.fault_flags = r_held_flags;
                    n_ovalid          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_sq_go      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_ref        <= RST_REFERENCE;
            r_gain       <= RST_GAIN;
            r_ofs        <= RST_OFFSET;
            r_held_temp  <= '0;
            r_held_flags <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_sq_go      <= n_sq_go;
            r_ovalid     <= n_ovalid;
            r_ref        <= n_ref;
            r_gain       <= n_gain;
            r_ofs        <= n_ofs;
            r_held_temp  <= n_held_temp;
            r_held_flags <= n_held_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_acc1  <= n_acc1;
        r_neg   <= n_neg;
        r_big   <= n_big;
        r_dvd   <= n_dvd;
        r_rem1  <= n_rem1;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_w     <= n_w;
        r_dvd2  <= n_dvd2;
        r_rem2  <= n_rem2;
        r_neg2  <= n_neg2;
        r_t     <= n_t;
        r_acc3  <= n_acc3;
        r_fresh <= n_fresh;
        r_clr   <= n_clr;
        r_out   <= n_out;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

endmodule

/* hw/rtl/rtdlin_checker.sv */
// Port-level checks for the RTD temperature linearizer, with the bind that
// attaches them to the top level. Depends on rtdlin_pkg for the result word type.
module rtdlin_checker import rtdlin_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_word
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("readout accepted while another is in work");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result word appeared without a readout in work");

    a_fresh_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.clear_fault |-> !i_out_word.fresh)
        else $error("fault clear requested on a fresh temperature");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("stalled result word changed");

endmodule

bind rtd_temperature_linearizer rtdlin_checker u_rtdlin_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.payload)
);
